@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is asserted.
`define ACG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define ACG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/acg_pkg.sv @@
// Shared types, constants and the arctangent table of the chirp coefficient generator.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package acg_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int INDEX_W     = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int RATE_W      = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int MIN_LENGTH  = 4;
  localparam int WORK_FRAC   = 30;
  localparam int ROT_W       = WORK_FRAC + 4;
  localparam int ATAN_DEPTH  = 24;
  localparam int CFG_SETTLE  = 2;

  localparam logic signed [ROT_W-1:0] GAIN_INIT = ROT_W'(652032874);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_IDLE  = 2'd2
  } acg_status_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHIRP_RATE   = 1'b0,
    CFG_SAMPLE_COUNT = 1'b1
  } acg_cfg_e;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               last;
    acg_status_e        status;
    logic [1:0]         quad;
  } acg_meta_t;

  typedef struct packed {
    logic [ROT_W-1:0] x;
    logic [ROT_W-1:0] y;
    logic [ROT_W-1:0] z;
  } acg_rot_t;

  // arctan(2^-i) in cycles, scaled by 2^32.
  function automatic logic signed [ROT_W-1:0] acg_atan(input int unsigned idx);
    case (idx)
      0:       acg_atan = ROT_W'(32'h2000_0000);
      1:       acg_atan = ROT_W'(32'h12E4_051E);
      2:       acg_atan = ROT_W'(32'h09FB_385B);
      3:       acg_atan = ROT_W'(32'h0511_11D4);
      4:       acg_atan = ROT_W'(32'h028B_0D43);
      5:       acg_atan = ROT_W'(32'h0145_D7E1);
      6:       acg_atan = ROT_W'(32'h00A2_F61E);
      7:       acg_atan = ROT_W'(32'h0051_7C55);
      8:       acg_atan = ROT_W'(32'h0028_BE53);
      9:       acg_atan = ROT_W'(32'h0014_5F2F);
      10:      acg_atan = ROT_W'(32'h000A_2F98);
      11:      acg_atan = ROT_W'(32'h0005_17CC);
      12:      acg_atan = ROT_W'(32'h0002_8BE6);
      13:      acg_atan = ROT_W'(32'h0001_45F3);
      14:      acg_atan = ROT_W'(32'h0000_A2FA);
      15:      acg_atan = ROT_W'(32'h0000_517D);
      16:      acg_atan = ROT_W'(32'h0000_28BE);
      17:      acg_atan = ROT_W'(32'h0000_145F);
      18:      acg_atan = ROT_W'(32'h0000_0A30);
      19:      acg_atan = ROT_W'(32'h0000_0518);
      20:      acg_atan = ROT_W'(32'h0000_028C);
      21:      acg_atan = ROT_W'(32'h0000_0146);
      22:      acg_atan = ROT_W'(32'h0000_00A3);
      23:      acg_atan = ROT_W'(32'h0000_0051);
      default: acg_atan = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ hdl/acg_phase_gen.sv @@
// Configuration registers, start-value precomputation and the second-order phase accumulator.
// Depends on acg_pkg; feeds the first CORDIC cell of the chain.
`default_nettype none

module acg_phase_gen #(
  parameter int PHASE_BITS = 32
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire [acg_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  wire [acg_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire                                 accept_i,
  input  wire                                 restart_i,
  input  wire                                 load_i,
  output logic                                busy_o,
  output logic                                valid_o,
  output acg_pkg::acg_meta_t                  meta_o,
  output acg_pkg::acg_rot_t                   rot_o
);
  import acg_pkg::*;

  localparam int HALF_W = LENGTH_BITS - 1;
  localparam int HH_W   = 2 * HALF_W;

  logic signed [RATE_W-1:0]      rate_q;
  logic [LENGTH_BITS-1:0]        count_q;
  logic [1:0]                    settle_q;
  logic [HH_W-1:0]               hh_q;
  logic [LENGTH_BITS-1:0]        dd_q;
  logic [PHASE_BITS-1:0]         init_acc_q;
  logic [PHASE_BITS-1:0]         init_delta_q;

  logic [LENGTH_BITS-1:0]        pos_q, pos_d;
  logic [PHASE_BITS-1:0]         acc_q, acc_d;
  logic [PHASE_BITS-1:0]         delta_q, delta_d;
  logic [LENGTH_BITS-1:0]        odd_q, odd_d;
  logic                          active_q, active_d;

  logic                          valid_q;
  acg_meta_t                     meta_q, meta_d;
  acg_rot_t                      rot_q, rot_d;

  logic [PHASE_BITS-1:0]         w_ext;
  logic [HALF_W-1:0]             half_c;
  logic [PHASE_BITS-1:0]         prod_acc, prod_delta;

  logic [LENGTH_BITS-1:0]        cur_pos, cur_odd;
  logic [PHASE_BITS-1:0]         cur_acc, cur_delta;
  acg_status_e                   status_c;
  logic                          last_c;
  logic [31:0]                   turn_c, u_c;
  logic [1:0]                    quad_c;

  assign w_ext  = PHASE_BITS'(rate_q);
  assign half_c = count_q[LENGTH_BITS-1:1];

  assign prod_acc   = w_ext * PHASE_BITS'(hh_q);
  assign prod_delta = w_ext * PHASE_BITS'(dd_q);

  assign busy_o  = cfg_we_i || (settle_q != 2'd0);
  assign valid_o = valid_q;
  assign meta_o  = meta_q;
  assign rot_o   = rot_q;

  // Configuration, settle counter and the two-step start-value pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q       <= '0;
      count_q      <= '0;
      settle_q     <= '0;
      hh_q         <= '0;
      dd_q         <= '0;
      init_acc_q   <= '0;
      init_delta_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CHIRP_RATE:   rate_q  <= cfg_data_i[RATE_W-1:0];
          CFG_SAMPLE_COUNT: count_q <= cfg_data_i[LENGTH_BITS-1:0];
          default: ;
        endcase
        settle_q <= 2'(CFG_SETTLE);
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
      hh_q         <= HH_W'(half_c) * HH_W'(half_c);
      dd_q         <= {half_c, 1'b0} - LENGTH_BITS'(1);
      init_acc_q   <= PHASE_BITS'(0) - prod_acc;
      init_delta_q <= prod_delta;
    end
  end

  always_comb begin
    cur_pos   = pos_q;
    cur_acc   = acc_q;
    cur_delta = delta_q;
    cur_odd   = odd_q;
    status_c  = ST_OK;
    if (restart_i) begin
      cur_pos   = '0;
      cur_acc   = init_acc_q;
      cur_delta = init_delta_q;
      cur_odd   = count_q | LENGTH_BITS'(1);
      if (count_q < LENGTH_BITS'(MIN_LENGTH)) begin
        status_c = ST_SHORT;
      end
    end else if (!active_q) begin
      status_c = ST_IDLE;
    end
    last_c = ({1'b0, cur_pos} + (LENGTH_BITS+1)'(1)) >= {1'b0, cur_odd};

    pos_d    = pos_q;
    acc_d    = acc_q;
    delta_d  = delta_q;
    odd_d    = odd_q;
    active_d = active_q;
    case (status_c)
      ST_SHORT: active_d = 1'b0;
      ST_OK: begin
        odd_d = cur_odd;
        if (last_c) begin
          active_d = 1'b0;
          pos_d    = cur_pos;
          acc_d    = cur_acc;
          delta_d  = cur_delta;
        end else begin
          active_d = 1'b1;
          pos_d    = cur_pos + LENGTH_BITS'(1);
          acc_d    = cur_acc + cur_delta;
          delta_d  = cur_delta - (w_ext << 1);
        end
      end
      default: ;
    endcase

    // Top 32 bits of the phase, then fold into the quadrant around zero.
    turn_c = 32'({cur_acc, 32'b0} >> PHASE_BITS);
    quad_c = 2'((turn_c + 32'h2000_0000) >> 30);
    u_c    = turn_c - {quad_c, 30'b0};

    meta_d.status = status_c;
    if (status_c == ST_OK) begin
      meta_d.index = INDEX_W'(cur_pos);
      meta_d.last  = last_c;
      meta_d.quad  = quad_c;
      rot_d.z      = ROT_W'(signed'(u_c));
    end else begin
      meta_d.index = '0;
      meta_d.last  = 1'b0;
      meta_d.quad  = '0;
      rot_d.z      = '0;
    end
    rot_d.x = GAIN_INIT;
    rot_d.y = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      acc_q    <= '0;
      delta_q  <= '0;
      odd_q    <= '0;
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      if (accept_i) begin
        pos_q    <= pos_d;
        acc_q    <= acc_d;
        delta_q  <= delta_d;
        odd_q    <= odd_d;
        active_q <= active_d;
      end
      if (load_i) begin
        valid_q <= accept_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && accept_i) begin
      meta_q <= meta_d;
      rot_q  <= rot_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/acg_cordic_cell.sv @@
// One rotation cell of the CORDIC chain, with its own valid and sideband register.
// Depends on acg_pkg for the data structs and the arctangent table.
`default_nettype none

module acg_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 en_i,
  input  wire                 valid_i,
  input  acg_pkg::acg_meta_t  meta_i,
  input  acg_pkg::acg_rot_t   rot_i,
  output logic                valid_o,
  output acg_pkg::acg_meta_t  meta_o,
  output acg_pkg::acg_rot_t   rot_o
);
  import acg_pkg::*;

  localparam logic signed [ROT_W-1:0] ANGLE = acg_atan(STAGE);

  logic signed [ROT_W-1:0] x_in, y_in, z_in, dx, dy;
  acg_rot_t                rot_d;
  logic                    valid_q;
  acg_meta_t               meta_q;
  acg_rot_t                rot_q;

  always_comb begin
    x_in = rot_i.x;
    y_in = rot_i.y;
    z_in = rot_i.z;
    dx   = y_in >>> STAGE;
    dy   = x_in >>> STAGE;
    if (!z_in[ROT_W-1]) begin
      rot_d.x = x_in - dx;
      rot_d.y = y_in + dy;
      rot_d.z = z_in - ANGLE;
    end else begin
      rot_d.x = x_in + dx;
      rot_d.y = y_in - dy;
      rot_d.z = z_in + ANGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      meta_q <= meta_i;
      rot_q  <= rot_d;
    end
  end

  assign valid_o = valid_q;
  assign meta_o  = meta_q;
  assign rot_o   = rot_q;

endmodule

`default_nettype wire

@@ hdl/acg_out_stage.sv @@
// Quadrant restore, rounding, saturation and the output register of the generator.
// Depends on acg_pkg; takes the last CORDIC cell of the chain.
`default_nettype none

module acg_out_stage (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            load_i,
  input  wire                            valid_i,
  input  acg_pkg::acg_meta_t             meta_i,
  input  acg_pkg::acg_rot_t              rot_i,
  output logic                           valid_o,
  output logic [acg_pkg::INDEX_W-1:0]    coef_index_o,
  output logic signed [acg_pkg::SAMPLE_BITS-1:0] h_real_o,
  output logic signed [acg_pkg::SAMPLE_BITS-1:0] h_imag_o,
  output logic                           last_o,
  output logic [1:0]                     status_o
);
  import acg_pkg::*;

  localparam int ROUND_SH = WORK_FRAC - (SAMPLE_BITS - 1);
  localparam logic signed [ROT_W-1:0] ROUND_HALF = ROT_W'(2 ** (ROUND_SH - 1));
  localparam logic signed [ROT_W-1:0] SAT_POS    = ROT_W'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [ROT_W-1:0] SAT_NEG    = -SAT_POS;

  function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic signed [ROT_W-1:0] v);
    logic signed [ROT_W-1:0] r;
    r = (v + ROUND_HALF) >>> ROUND_SH;
    if (r > SAT_POS) begin
      r = SAT_POS;
    end else if (r < SAT_NEG) begin
      r = SAT_NEG;
    end
    round_sat = r[SAMPLE_BITS-1:0];
  endfunction

  logic signed [ROT_W-1:0] x_in, y_in, cos_c, sin_c;
  logic                    valid_q;

  always_comb begin
    x_in = rot_i.x;
    y_in = rot_i.y;
    case (meta_i.quad)
      2'd0: begin
        cos_c = x_in;
        sin_c = y_in;
      end
      2'd1: begin
        cos_c = -y_in;
        sin_c = x_in;
      end
      2'd2: begin
        cos_c = -x_in;
        sin_c = -y_in;
      end
      default: begin
        cos_c = y_in;
        sin_c = -x_in;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      coef_index_o <= meta_i.index;
      last_o       <= meta_i.last;
      status_o     <= meta_i.status;
      if (meta_i.status == ST_OK) begin
        h_real_o <= round_sat(cos_c);
        h_imag_o <= round_sat(sin_c);
      end else begin
        h_real_o <= '0;
        h_imag_o <= '0;
      end
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

@@ hdl/azimuth_chirp_coefficient_generator.sv @@
// Top level of the azimuth chirp coefficient generator: phase front end, CORDIC cell chain,
// output stage. Depends on acg_pkg, acg_phase_gen, acg_cordic_cell and acg_out_stage.
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       in_valid_i / in_stall_o   restart_i
//   out      source     out_valid_o / out_stall_i coef_index_o, h_real_o, h_imag_o,
//                                                 last_o, status_o
//   cfg      sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// One transaction is accepted per clock cycle while in_stall_o is low. The phase register
// is loaded at the edge that accepts an input transaction; the result then passes through
// one register per CORDIC cell and the output register to the output port.
// After a configuration write the input is stalled from the write cycle until the settle
// counter has run down, while the squared half length and the start phase are recomputed.
// Reset is asynchronous and active low; it clears all configuration and sequence state.
// A stalled output only holds the cells that are full: empty slots further up the chain
// keep filling, so input transactions are still taken while a result waits.
`default_nettype none

module azimuth_chirp_coefficient_generator #(
  parameter int PHASE_BITS    = 32,
  parameter int CORDIC_STAGES = 16
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_we_i,
  input  wire [acg_pkg::CFG_INDEX_W-1:0]         cfg_index_i,
  input  wire [acg_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire                                    restart_i,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic [acg_pkg::INDEX_W-1:0]            coef_index_o,
  output logic signed [acg_pkg::SAMPLE_BITS-1:0] h_real_o,
  output logic signed [acg_pkg::SAMPLE_BITS-1:0] h_imag_o,
  output logic                                   last_o,
  output logic [1:0]                             status_o
);
  import acg_pkg::*;

  // Stage 0 is the phase register; stage k+1 is the register of cell k.
  logic      stage_valid [0:CORDIC_STAGES];
  acg_meta_t stage_meta  [0:CORDIC_STAGES];
  acg_rot_t  stage_rot   [0:CORDIC_STAGES];
  // advance[k] is high when stage k may take new data this cycle.
  logic      advance     [0:CORDIC_STAGES+1];

  logic busy;
  logic accept;

  assign advance[CORDIC_STAGES+1] = !out_valid_o || !out_stall_i;

  for (genvar k = 0; k <= CORDIC_STAGES; k++) begin : g_adv
    assign advance[k] = !stage_valid[k] || advance[k+1];
  end

  assign in_stall_o = busy || !advance[0];
  assign accept     = in_valid_i && !in_stall_o;

  // The accumulator sees each accepted transaction exactly once, in order.
  acg_phase_gen #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .restart_i   (restart_i),
    .load_i      (advance[0]),
    .busy_o      (busy),
    .valid_o     (stage_valid[0]),
    .meta_o      (stage_meta[0]),
    .rot_o       (stage_rot[0])
  );

  // Chain of rotation cells, each shifting by its own stage number.
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    acg_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance[k+1]),
      .valid_i (stage_valid[k]),
      .meta_i  (stage_meta[k]),
      .rot_i   (stage_rot[k]),
      .valid_o (stage_valid[k+1]),
      .meta_o  (stage_meta[k+1]),
      .rot_o   (stage_rot[k+1])
    );
  end

  // Quadrant fold-back, rounding to Q1.15 and the registered output.
  acg_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance[CORDIC_STAGES+1]),
    .valid_i      (stage_valid[CORDIC_STAGES]),
    .meta_i       (stage_meta[CORDIC_STAGES]),
    .rot_i        (stage_rot[CORDIC_STAGES]),
    .valid_o      (out_valid_o),
    .coef_index_o (coef_index_o),
    .h_real_o     (h_real_o),
    .h_imag_o     (h_imag_o),
    .last_o       (last_o),
    .status_o     (status_o)
  );

endmodule

`default_nettype wire

@@ hdl/acg_checker.sv @@
// Port-level checks of the chirp coefficient generator, bound to its top level.
// Depends on acg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module acg_checker (
  input wire                                    clk_i,
  input wire                                    rst_ni,
  input wire                                    cfg_we_i,
  input wire                                    in_stall_o,
  input wire                                    out_valid_o,
  input wire                                    out_stall_i,
  input wire [acg_pkg::INDEX_W-1:0]             coef_index_o,
  input wire signed [acg_pkg::SAMPLE_BITS-1:0]  h_real_o,
  input wire signed [acg_pkg::SAMPLE_BITS-1:0]  h_imag_o,
  input wire                                    last_o,
  input wire [1:0]                              status_o
);
  import acg_pkg::*;

  // A rejected or idle request carries no coefficient.
  `ACG_ASSERT(a_fail_fields_zero, clk_i, rst_ni, out_valid_o && (status_o != ST_OK) |-> (h_real_o == '0) && (h_imag_o == '0) && (coef_index_o == '0) && !last_o, "failed transaction with non-zero fields")

  // Saturation keeps the most negative code off both outputs.
  `ACG_ASSERT(a_sat_range, clk_i, rst_ni, out_valid_o |-> (h_real_o != 16'h8000) && (h_imag_o != 16'h8000), "coefficient outside saturation range")

  // A stalled result stays on the port unchanged.
  `ACG_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(coef_index_o) && $stable(h_real_o) && $stable(h_imag_o) && $stable(status_o), "stalled result changed")

  // The start-value pipeline must settle before the next transaction is taken.
  `ACG_ASSERT(a_cfg_settle, clk_i, rst_ni, cfg_we_i |=> in_stall_o, "input taken while configuration settles")

  // No result is offered while reset is held.
  `ACG_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind azimuth_chirp_coefficient_generator acg_checker u_acg_checker (.*);

`default_nettype wire

@@ dv/acg_coef_sb_pkg.sv @@
// Scoreboard for the azimuth chirp coefficient generator: a bit-exact predictor and the
// queue of coefficients it expects. Depends on acg_pkg for the status and register codes.
`timescale 1ns / 100ps

package acg_coef_sb_pkg;
  import acg_pkg::*;

  typedef struct {
    logic [15:0]        index;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               last;
    acg_status_e        status;
  } coef_t;

  class coef_scoreboard;
    coef_t       expected_coefs[$];
    logic [31:0] chirp_rate;
    logic [15:0] sample_count;
    logic [15:0] position;
    logic [15:0] odd_length;
    logic [31:0] phase_acc;
    logic [31:0] phase_delta;
    bit          running;
    int          errors;
    int          reported;
    longint      atan_turns[16];

    function new();
      chirp_rate   = '0;
      sample_count = '0;
      position     = '0;
      odd_length   = '0;
      phase_acc    = '0;
      phase_delta  = '0;
      running      = 1'b0;
      errors       = 0;
      reported     = 0;
      atan_turns   = '{64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
                       64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
                       64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
                       64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA, 64'h0000_517D};
    endfunction

    function void write_reg(acg_cfg_e idx, logic [31:0] value);
      case (idx)
        CFG_CHIRP_RATE:   chirp_rate = value;
        CFG_SAMPLE_COUNT: sample_count = value[15:0];
        default: ;
      endcase
    endfunction

    // Rounds a Q2.30 working value to Q1.15 and clips it symmetrically.
    function logic signed [15:0] round_sat(longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32767) r = -32767;
      return r[15:0];
    endfunction

    function void cordic_rotate(logic [31:0] turn, output logic signed [15:0] cos_out,
                                output logic signed [15:0] sin_out);
      logic [1:0]  quad;
      logic [31:0] rem;
      longint      x, y, z, dx, dy, c, s;
      quad = 2'((turn + 32'h2000_0000) >> 30);
      rem  = turn - {quad, 30'd0};
      z    = longint'($signed(rem));
      x    = 64'sd652032874;
      y    = 0;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - atan_turns[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + atan_turns[i];
        end
      end
      case (quad)
        2'd0:    begin c = x;  s = y;  end
        2'd1:    begin c = -y; s = x;  end
        2'd2:    begin c = -x; s = -y; end
        default: begin c = y;  s = -x; end
      endcase
      cos_out = round_sat(c);
      sin_out = round_sat(s);
    endfunction

    // Works out the coefficient that one accepted request produces.
    function void note_request(logic restart);
      coef_t       e;
      logic [31:0] half;
      e.index  = '0;
      e.re     = '0;
      e.im     = '0;
      e.last   = 1'b0;
      e.status = ST_OK;
      if (restart) begin
        if (sample_count < MIN_LENGTH) begin
          running  = 1'b0;
          e.status = ST_SHORT;
          expected_coefs.push_back(e);
          return;
        end
        odd_length  = sample_count | 16'd1;
        half        = 32'(odd_length >> 1);
        position    = '0;
        phase_acc   = 32'd0 - chirp_rate * half * half;
        phase_delta = chirp_rate * (32'd2 * half - 32'd1);
        running     = 1'b1;
      end else if (!running) begin
        e.status = ST_IDLE;
        expected_coefs.push_back(e);
        return;
      end
      cordic_rotate(phase_acc, e.re, e.im);
      e.index = position;
      if ({1'b0, position} + 17'd1 >= {1'b0, odd_length}) begin
        e.last  = 1'b1;
        running = 1'b0;
      end else begin
        position    = position + 16'd1;
        phase_acc   = phase_acc + phase_delta;
        phase_delta = phase_delta - {chirp_rate[30:0], 1'b0};
      end
      expected_coefs.push_back(e);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        if (reported < 50) begin
          reported++;
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
      end
    endfunction

    function void check_coef(logic [15:0] index, logic signed [15:0] re,
                             logic signed [15:0] im, logic last, logic [1:0] status);
      coef_t e;
      if (expected_coefs.size() == 0) begin
        errors++;
        if (reported < 50) begin
          reported++;
          $display("%0t: unexpected result, expected none, actual index %0d status %0d",
                   $time, index, status);
        end
        return;
      end
      e = expected_coefs.pop_front();
      compare_field("coef_index", e.index, index);
      compare_field("h_real", e.re, re);
      compare_field("h_imag", e.im, im);
      compare_field("last", e.last, last);
      compare_field("status", e.status, status);
    endfunction

    function int pending();
      return expected_coefs.size();
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
// Top-level testbench of the azimuth chirp coefficient generator: clock, reset, drivers,
// monitors and watchdog. Depends on acg_pkg, acg_coef_sb_pkg and the block itself.
`timescale 1ns / 100ps

module tb_top;
  import acg_pkg::*;
  import acg_coef_sb_pkg::*;

  // Pipeline depth of the block: the phase register, one register per CORDIC cell and the output register.
  localparam int PIPE_DEPTH    = 16 + 2;
  localparam int SETTLE_CYCLES = 4;
  localparam int ITEM_TARGET   = 800;
  localparam int IDLE_LIMIT    = 2000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [CFG_INDEX_W-1:0]        cfg_index_i;
  logic [CFG_DATA_W-1:0]         cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          restart_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [INDEX_W-1:0]            coef_index_o;
  logic signed [SAMPLE_BITS-1:0] h_real_o;
  logic signed [SAMPLE_BITS-1:0] h_imag_o;
  logic                          last_o;
  logic [1:0]                    status_o;

  coef_scoreboard sb = new();

  int          items_sent  = 0;
  int          burst_left  = 0;
  int          stall_mode  = 0;
  int          stall_left  = 0;
  int          quiet_count = 0;
  logic [15:0] cur_count   = '0;

  azimuth_chirp_coefficient_generator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .coef_index_o(coef_index_o),
    .h_real_o    (h_real_o),
    .h_imag_o    (h_imag_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

  always #10 clk_i = ~clk_i;

  // Monitors. Every input is driven with nonblocking assignments at the rising edge, so
  // the values read here are the ones that the block samples at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(acg_cfg_e'(cfg_index_i), cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_request(restart_i);
      if (out_valid_o && !out_stall_i)
        sb.check_coef(coef_index_o, h_real_o, h_imag_o, last_o, status_o);
    end
  end

  // The receiver changes its behaviour every so often: no stalls at all, light or heavy
  // random stalls, or a fixed rhythm of long stalls followed by a free window.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 9) < 3);
        2:       out_stall_i <= ($urandom_range(0, 9) < 8);
        default: out_stall_i <= ((stall_left % 32) < 20);
      endcase
    end
  end

  // The watchdog ends the run once no transaction has taken place on either channel for
  // far longer than the slowest correct run could need.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_count = 0;
    else quiet_count++;
    if (quiet_count >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one request and returns at the edge where it is taken. The sender works in
  // bursts: when one runs out it usually drops valid for a random gap before the next.
  task automatic send_item(logic restart);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Holds the sender back until every expected coefficient has arrived, then lets the
  // pipeline settle so that a register write finds the block idle. The first edge lets
  // the monitor note a request taken at the edge on which this task is entered.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // A write takes effect at the edge where the enable is high; the enable is then dropped
  // before the task returns, so that back-to-back writes never collide within one time step.
  task automatic write_reg(acg_cfg_e idx, logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_SAMPLE_COUNT) cur_count = value[15:0];
  endtask

  // A well-formed sequence is a restart followed by the rest of the filter. Long filters
  // are cut to a few dozen coefficients, and now and then a sequence is broken off early.
  task automatic send_sequence();
    int steps;
    send_item(1'b1);
    if (cur_count >= MIN_LENGTH) begin
      steps = int'(cur_count | 16'd1) - 1;
      if (steps > 60) steps = $urandom_range(3, 60);
      if ($urandom_range(0, 7) == 0) steps = $urandom_range(0, steps);
      repeat (steps) send_item(1'b0);
    end
  endtask

  initial begin
    int phase_end;
    bit first_phase;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_CHIRP_RATE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    restart_i   = 1'b0;
    out_stall_i = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part. Straight after reset a continuation request finds no sequence, and a
    // restart finds a length of zero.
    send_item(1'b0);
    send_item(1'b1);

    // A length of three is still too short; the continuation after it is an idle request.
    drain_results();
    write_reg(CFG_SAMPLE_COUNT, 32'd3);
    send_item(1'b1);
    send_item(1'b0);

    // The shortest legal length, even so rounded up to five, at the largest positive rate,
    // followed by one request past the end of the sequence.
    drain_results();
    write_reg(CFG_CHIRP_RATE, 32'h7FFF_FFFF);
    write_reg(CFG_SAMPLE_COUNT, 32'd4);
    send_sequence_full(5);
    send_item(1'b0);

    // An odd length at the most negative rate.
    drain_results();
    write_reg(CFG_CHIRP_RATE, 32'h8000_0000);
    write_reg(CFG_SAMPLE_COUNT, 32'd5);
    send_sequence_full(5);

    // The longest filter, restarted while it is running.
    drain_results();
    write_reg(CFG_CHIRP_RATE, 32'hFFFF_FFFF);
    write_reg(CFG_SAMPLE_COUNT, 32'd65535);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);

    // The chirp rate changes under a running sequence and applies from the next step.
    drain_results();
    write_reg(CFG_CHIRP_RATE, 32'h1234_5678);
    send_item(1'b0);
    send_item(1'b0);

    // A new length only counts from the next restart; the largest even count rounds up.
    drain_results();
    write_reg(CFG_SAMPLE_COUNT, 32'd65534);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);

    // Random part, in phases. Each phase begins with the block drained, which also gives
    // the pauses in which the sender waits for every outstanding result. Some phases keep
    // the previous settings, so running sequences carry on across the pause.
    first_phase = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      drain_results();
      if (first_phase || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(CFG_CHIRP_RATE, 32'h8000_0000);
          1:       write_reg(CFG_CHIRP_RATE, 32'h7FFF_FFFF);
          2:       write_reg(CFG_CHIRP_RATE, 32'h0000_0000);
          3:       write_reg(CFG_CHIRP_RATE, 32'($urandom_range(0, 2000)) - 32'd1000);
          default: write_reg(CFG_CHIRP_RATE, $urandom);
        endcase
      end
      if (first_phase || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       write_reg(CFG_SAMPLE_COUNT, 32'($urandom_range(0, 3)));
          1:       write_reg(CFG_SAMPLE_COUNT, {16'd0, 16'($urandom)});
          2:       write_reg(CFG_SAMPLE_COUNT, 32'd65535);
          default: write_reg(CFG_SAMPLE_COUNT, 32'($urandom_range(4, 40)));
        endcase
      end
      first_phase = 1'b0;
      phase_end = items_sent + $urandom_range(30, 90);
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          8:       repeat ($urandom_range(1, 3)) send_item(1'b0);
          9:       repeat ($urandom_range(1, 5)) send_item(1'($urandom_range(0, 1)));
          default: send_sequence();
        endcase
      end
    end

    drain_results();
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Sends a restart and then continuation requests up to the given filter length.
  task automatic send_sequence_full(int length);
    send_item(1'b1);
    repeat (length - 1) send_item(1'b0);
  endtask

endmodule
